>>> rtl/mct_pkg.sv
// mct_pkg: shared types and constants of the mouse cursor tracker
// no dependencies; used by the channel interfaces and all rtl modules
`default_nettype none

package mct_pkg;

	localparam int SCREEN_WIDTH_DEF  = 800;
	localparam int SCREEN_HEIGHT_DEF = 1024;

	localparam int COUNT_W  = 12;
	localparam int LAST_W   = 13;
	localparam int ZERO_W   = 16;
	localparam int AXIS_W   = 12;
	localparam int POS_W    = 10;
	localparam int QUAD_W   = 2;
	localparam int OFF_W    = 6;
	localparam int CLAMP_W  = 14;

	localparam int HALF_RANGE  = 2048;
	localparam int FULL_RANGE  = 4096;
	localparam int SPRITE_SIZE = 16;

	localparam logic signed [OFF_W-1:0] OFF_STD  = -6'sd16;
	localparam logic signed [OFF_W-1:0] OFF_USER = -6'sd8;
	localparam logic signed [OFF_W-1:0] OFF_NONE = 6'sd0;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_USER_CURSOR    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REDRAW_INHIBIT = 1'd1;

	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_SET    = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [COUNT_W-1:0] raw_x;
		logic [COUNT_W-1:0] raw_y;
		logic [POS_W-1:0]   set_x;
		logic [POS_W-1:0]   set_y;
	} mct_in_t;

	typedef struct packed {
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic [QUAD_W-1:0] quadrant;
		logic              moved;
		logic              redraw;
		logic              erase_old;
		logic [POS_W-1:0]  old_x;
		logic [POS_W-1:0]  old_y;
		logic [QUAD_W-1:0] old_quadrant;
		logic [POS_W-1:0]  sprite_x;
		logic [POS_W-1:0]  sprite_y;
	} mct_out_t;

endpackage

`default_nettype wire

>>> rtl/mct_in_if.sv
// mct_in_if: valid/ready channel carrying one mouse sample or set request
// depends on mct_pkg for the payload type
`default_nettype none

interface mct_in_if import mct_pkg::*; ();
	logic    valid;
	logic    ready;
	mct_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/mct_out_if.sv
// mct_out_if: valid/ready channel carrying one cursor result
// depends on mct_pkg for the payload type
`default_nettype none

interface mct_out_if import mct_pkg::*; ();
	logic     valid;
	logic     ready;
	mct_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/mct_axis.sv
// mct_axis: one cursor axis; unwraps the mouse counter, holds last count and
// zero offset, clamps the distance to the screen size
// depends on mct_pkg
`default_nettype none

module mct_axis import mct_pkg::*; #(
	parameter int SIZE = SCREEN_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     set_mode,
	input  wire logic signed [LAST_W-1:0] count,
	input  wire logic [POS_W-1:0]         set_val,
	output logic [AXIS_W-1:0]             pos
);

	localparam int DIFF_W = ZERO_W + 1;

	logic signed [LAST_W-1:0] last_q;
	logic signed [ZERO_W-1:0] zero_q;

	logic signed [LAST_W-1:0] v;
	logic signed [LAST_W:0]   jump;
	logic signed [ZERO_W-1:0] zero_a;
	logic signed [ZERO_W-1:0] zero_b;
	logic signed [ZERO_W-1:0] zero_n;
	logic signed [DIFF_W-1:0] span;
	logic signed [DIFF_W-1:0] set_diff;

	always_comb begin
		v        = (set_mode == MODE_SET) ? last_q : count;
		set_diff = DIFF_W'(last_q) - $signed({{(DIFF_W-POS_W){1'b0}}, set_val});
		zero_a   = (set_mode == MODE_SET) ? set_diff[ZERO_W-1:0] : zero_q;
		jump     = (LAST_W+1)'(v) - (LAST_W+1)'(last_q);
		if (jump > (LAST_W+1)'(HALF_RANGE)) begin
			zero_b = zero_a + ZERO_W'(FULL_RANGE);
		end else if (jump < -(LAST_W+1)'(HALF_RANGE)) begin
			zero_b = zero_a - ZERO_W'(FULL_RANGE);
		end else begin
			zero_b = zero_a;
		end
		span = DIFF_W'(v) - DIFF_W'(zero_b);
		if (span < 0) begin
			zero_n = ZERO_W'(v);
			pos    = '0;
		end else if (span >= $signed(DIFF_W'(SIZE))) begin
			zero_n = ZERO_W'(v) - ZERO_W'(SIZE);
			pos    = AXIS_W'(SIZE - 1);
		end else begin
			zero_n = zero_b;
			pos    = span[AXIS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			zero_q <= '0;
		end else if (en) begin
			last_q <= v;
			zero_q <= zero_n;
		end
	end

endmodule

`default_nettype wire

>>> rtl/mouse_cursor_tracker_top.sv
// mouse_cursor_tracker_top: mouse counters to clamped cursor position with
// quadrant choice, sprite origins and redraw/erase requests
// depends on mct_pkg, mct_in_if, mct_out_if, mct_axis
//
// usage: the sample channel carries one item per transfer, either a reading
// of the free-running 12-bit mouse counters (mode 0) or a requested cursor
// position (mode 1). every item gives exactly one result on the cursor
// channel: new position, quadrant, moved/redraw/erase flags, the previous
// cursor state and the new sprite origin.
// each item passes the input register, then the unwrap/clamp/quadrant logic
// into the result register.
// throughput is one item per cycle while the receiver does not stall; the cursor state registers update in the
// same edge that loads the result register, so the next item sees them.
// when the receiver stalls the result holds and the input register fills;
// ready on the sample channel drops only when both are occupied.
// reset clears counters, offsets, cursor state, both config registers and
// all valid flags. config writes (cfg_we, cfg_idx, cfg_data) take effect at
// once and are meant to happen only while no item is in flight.
`default_nettype none

module mouse_cursor_tracker_top import mct_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic                 cfg_data,
	mct_in_if.sink                    sample,
	mct_out_if.source                 cursor
);

	localparam int X_LEFT  = SCREEN_WIDTH / 3;
	localparam int X_RIGHT = SCREEN_WIDTH * 2 / 3;
	localparam int Y_TOP   = SCREEN_HEIGHT / 3;
	localparam int Y_BOT   = SCREEN_HEIGHT * 2 / 3;
	localparam int X_MAX   = SCREEN_WIDTH - SPRITE_SIZE - 1;
	localparam int Y_MAX   = SCREEN_HEIGHT - SPRITE_SIZE - 1;

	logic              user_cursor_q;
	logic              redraw_inhibit_q;
	logic [POS_W-1:0]  cur_x_q;
	logic [POS_W-1:0]  cur_y_q;
	logic [QUAD_W-1:0] cur_quad_q;
	logic              shown_q;

	logic     v_s1;
	mct_in_t  item_s1;
	logic     v_s2;
	mct_out_t res_s2;

	logic     adv;
	logic     step;
	mct_out_t res;

	logic signed [LAST_W-1:0] cnt_x;
	logic signed [LAST_W-1:0] cnt_y;
	logic [AXIS_W-1:0]        ax_x;
	logic [AXIS_W-1:0]        ax_y;

	logic [QUAD_W-1:0]         quad;
	logic signed [OFF_W-1:0]   dx;
	logic signed [OFF_W-1:0]   dy;
	logic signed [CLAMP_W-1:0] x0, x1, x2;
	logic signed [CLAMP_W-1:0] y0, y1, y2;
	logic [POS_W-1:0]          nx;
	logic [POS_W-1:0]          ny;
	logic                      moved;
	logic                      redraw;
	logic [POS_W-1:0]          px;
	logic [POS_W-1:0]          py;
	logic [QUAD_W-1:0]         pq;
	logic signed [OFF_W-1:0]   sdx;
	logic signed [OFF_W-1:0]   sdy;
	logic signed [POS_W+1:0]   ex;
	logic signed [POS_W+1:0]   ey;

	// handshake
	assign adv          = !v_s2 || cursor.ready;
	assign sample.ready = !v_s1 || adv;
	assign step         = v_s1 && adv;
	assign cursor.valid = v_s2;
	assign cursor.data  = res_s2;

	// y counter is negated
	assign cnt_x = $signed({1'b0, item_s1.raw_x});
	assign cnt_y = LAST_W'(0) - $signed({1'b0, item_s1.raw_y});

	mct_axis #(.SIZE(SCREEN_WIDTH)) u_axis_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (step),
		.set_mode (item_s1.mode),
		.count    (cnt_x),
		.set_val  (item_s1.set_x),
		.pos      (ax_x)
	);

	mct_axis #(.SIZE(SCREEN_HEIGHT)) u_axis_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (step),
		.set_mode (item_s1.mode),
		.count    (cnt_y),
		.set_val  (item_s1.set_y),
		.pos      (ax_y)
	);

	always_comb begin
		// quadrant with hysteresis
		quad = cur_quad_q;
		if ({1'b0, ax_x} < (AXIS_W+1)'(X_LEFT)) quad[0] = 1'b1;
		if ({1'b0, ax_x} > (AXIS_W+1)'(X_RIGHT)) quad[0] = 1'b0;
		if ({1'b0, ax_y} < (AXIS_W+1)'(Y_TOP)) quad[1] = 1'b0;
		if ({1'b0, ax_y} > (AXIS_W+1)'(Y_BOT)) quad[1] = 1'b1;

		dx = user_cursor_q ? OFF_USER : (quad[0] ? OFF_NONE : OFF_STD);
		dy = user_cursor_q ? OFF_USER : (quad[1] ? OFF_STD : OFF_NONE);

		// keep the sprite on screen
		x0 = $signed({{(CLAMP_W-AXIS_W){1'b0}}, ax_x});
		y0 = $signed({{(CLAMP_W-AXIS_W){1'b0}}, ax_y});
		x1 = (x0 < -CLAMP_W'(dx)) ? -CLAMP_W'(dx) : x0;
		y1 = (y0 < -CLAMP_W'(dy)) ? -CLAMP_W'(dy) : y0;
		x2 = (x1 > CLAMP_W'(X_MAX) - CLAMP_W'(dx)) ? CLAMP_W'(X_MAX) - CLAMP_W'(dx) : x1;
		y2 = (y1 > CLAMP_W'(Y_MAX) - CLAMP_W'(dy)) ? CLAMP_W'(Y_MAX) - CLAMP_W'(dy) : y1;
		nx = x2[POS_W-1:0];
		ny = y2[POS_W-1:0];

		moved  = !(nx == cur_x_q && ny == cur_y_q && shown_q);
		redraw = moved && !redraw_inhibit_q;

		px = moved ? nx : cur_x_q;
		py = moved ? ny : cur_y_q;
		pq = moved ? quad : cur_quad_q;

		sdx = user_cursor_q ? OFF_USER : (pq[0] ? OFF_NONE : OFF_STD);
		sdy = user_cursor_q ? OFF_USER : (pq[1] ? OFF_STD : OFF_NONE);
		ex  = $signed({2'b00, px}) + (POS_W+2)'(sdx);
		ey  = $signed({2'b00, py}) + (POS_W+2)'(sdy);

		res.pos_x        = px;
		res.pos_y        = py;
		res.quadrant     = pq;
		res.moved        = moved;
		res.redraw       = redraw;
		res.erase_old    = redraw && shown_q;
		res.old_x        = cur_x_q;
		res.old_y        = cur_y_q;
		res.old_quadrant = cur_quad_q;
		res.sprite_x     = (ex < 0) ? '0 : ex[POS_W-1:0];
		res.sprite_y     = (ey < 0) ? '0 : ey[POS_W-1:0];
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_cursor_q    <= 1'b0;
			redraw_inhibit_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_USER_CURSOR:    user_cursor_q    <= cfg_data;
				CFG_REDRAW_INHIBIT: redraw_inhibit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			cur_quad_q <= '0;
			shown_q    <= 1'b0;
		end else if (step && moved) begin
			cur_x_q    <= nx;
			cur_y_q    <= ny;
			cur_quad_q <= quad;
			if (redraw) shown_q <= 1'b1;
		end
	end

	// input and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (sample.ready) v_s1 <= sample.valid;
			if (adv) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) item_s1 <= sample.data;
		if (step) res_s2 <= res;
	end

endmodule

`default_nettype wire
